@@ hdl/pfds_pkg.sv @@
// pfds_pkg: shared types and constants of the phase field degraded stress core
// holds the input and result item structs and the fixed field widths
// no dependencies
package pfds_pkg;

  // spatial dimension, 2 or 3
  localparam int DIM   = 3;
  localparam int NAX   = 3;
  localparam int NCOMP = NAX * NAX;

  localparam int EW   = 32;   // strain, signed Q1.30
  localparam int MODW = 32;   // lame moduli, unsigned integer
  localparam int QW   = 17;   // Q0.16 fields with one as 65536
  localparam int FRAC = 16;
  localparam int SW   = 64;   // stress result

  localparam logic [QW-1:0] ONE_Q16 = QW'(1) << FRAC;

  typedef struct packed {
    logic signed [EW-1:0] strain_xx;
    logic signed [EW-1:0] strain_xy;
    logic signed [EW-1:0] strain_xz;
    logic signed [EW-1:0] strain_yx;
    logic signed [EW-1:0] strain_yy;
    logic signed [EW-1:0] strain_yz;
    logic signed [EW-1:0] strain_zx;
    logic signed [EW-1:0] strain_zy;
    logic signed [EW-1:0] strain_zz;
    logic [MODW-1:0]      lame_first;
    logic [MODW-1:0]      shear_modulus;
    logic [QW-1:0]        damage;
  } point_t;

  typedef struct packed {
    logic signed [SW-1:0] stress_xx;
    logic signed [SW-1:0] stress_xy;
    logic signed [SW-1:0] stress_xz;
    logic signed [SW-1:0] stress_yx;
    logic signed [SW-1:0] stress_yy;
    logic signed [SW-1:0] stress_yz;
    logic signed [SW-1:0] stress_zx;
    logic signed [SW-1:0] stress_zy;
    logic signed [SW-1:0] stress_zz;
  } stress_t;

endpackage

@@ hdl/phase_field_degraded_stress_core.sv @@
// phase_field_degraded_stress_core: degraded stress of one material point with the
// volumetric / deviatoric split, 13 stage pipeline with nine component lanes
// depends on pfds_pkg
//
//   channel  | valid        | stall        | payload            | direction
//   ---------+--------------+--------------+--------------------+----------
//   point    | point_valid  | point_stall  | point (point_t)    | in
//   stress   | stress_valid | stress_stall | stress (stress_t)  | out
//   cfg      | cfg_we       | none         | cfg_wdata (k)      | in
//
// one item per cycle while stress_stall is low; each item passes through every stage in order
// the depth is set by the wide product split into partial products and the
// three radix-16 divide-by-3 stages
// rst is synchronous and clears the valid bits and the residual stiffness
// a stall holds only the stages that are full; empty stages keep filling
module phase_field_degraded_stress_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [pfds_pkg::QW-1:0] cfg_wdata,
  input  logic                    point_valid,
  output logic                    point_stall,
  input  pfds_pkg::point_t        point,
  output logic                    stress_valid,
  input  logic                    stress_stall,
  output pfds_pkg::stress_t       stress
);

  localparam int DIM   = pfds_pkg::DIM;
  localparam int NAX   = pfds_pkg::NAX;
  localparam int NCOMP = pfds_pkg::NCOMP;
  localparam int EW    = pfds_pkg::EW;
  localparam int MODW  = pfds_pkg::MODW;
  localparam int QW    = pfds_pkg::QW;
  localparam int FRAC  = pfds_pkg::FRAC;
  localparam int SW    = pfds_pkg::SW;

  localparam int TW   = EW + 2;          // trace
  localparam int LW   = MODW + 3;        // 3 lambda + 2 mu
  localparam int E6W  = EW + 3;          // 6 E
  localparam int CW   = EW + 4;          // 6 E - 2 tr
  localparam int AW   = 2 * EW + 5;      // multiplier of g
  localparam int BW   = AW + 1;          // 2 b + 3
  localparam int OM2W = 2 * FRAC + 1;
  localparam int GW   = 3 * FRAC + 1;    // g in Q0.48
  localparam int GLW  = 32;
  localparam int GHW  = GW - GLW;
  localparam int ALW  = 35;
  localparam int AHW  = AW - ALW;
  localparam int PLLW = GLW + ALW;
  localparam int PLHW = GHW + ALW;
  localparam int PHLW = GLW + 1 + AHW;
  localparam int PHHW = GHW + 1 + AHW;
  localparam int XW   = 120;
  localparam int QSH  = 3 * FRAC;
  localparam int ZW   = XW - QSH;
  localparam int DGW  = 4;
  localparam int DIV_STAGES = 3;
  localparam int CHW  = ZW / DIV_STAGES;
  localparam int DPS  = CHW / DGW;

  localparam int ST_PREP = 1;
  localparam int ST_COEF = 2;
  localparam int ST_MULA = 3;
  localparam int ST_ACOL = 4;
  localparam int ST_PP   = 5;
  localparam int ST_SUM1 = 6;
  localparam int ST_SUM2 = 7;
  localparam int ST_RND  = 8;
  localparam int ST_MAG  = 9;
  localparam int ST_DIV0 = 10;
  localparam int ST_OUT  = ST_DIV0 + DIV_STAGES;
  localparam int NSTG    = ST_OUT;

  localparam logic signed [BW-1:0] RND_HALF = BW'(3);   // 3 * 2^47 in units of 2^47
  localparam logic [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic [CHW-1:0] q;
    logic [1:0]     r;
  } div3_t;

  // long division by 3 over one chunk, one hex digit a step
  function automatic div3_t div3_chunk(input logic [1:0] rin, input logic [CHW-1:0] chunk);
    div3_t      res;
    logic [5:0] cur;
    logic [3:0] qd;
    res.r = rin;
    res.q = '0;
    for (int n = DPS - 1; n >= 0; n--) begin
      cur = {res.r, chunk[n*DGW +: DGW]};
      qd  = '0;
      for (int t = 1; t < 16; t++) begin
        if (cur >= 6'(3 * t)) begin
          qd = 4'(t);
        end
      end
      res.q[n*DGW +: DGW] = qd;
      res.r = 2'(cur - ((6'(qd) << 1) + 6'(qd)));
    end
    return res;
  endfunction

  // configuration and handshake
  logic [QW-1:0]   k_reg;
  logic [NSTG:1]   vld;
  logic [NSTG:1]   vld_shift;
  logic [NSTG+1:1] rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= '0;
    end else if (cfg_we) begin
      k_reg <= cfg_wdata;
    end
  end

  always_comb begin
    rdy[NSTG+1] = !stress_stall;
    for (int s = NSTG; s >= 1; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign vld_shift    = {vld[NSTG-1:1], point_valid};
  assign point_stall  = !rdy[1];
  assign stress_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 1; s <= NSTG; s++) begin
        if (rdy[s]) begin
          vld[s] <= vld_shift[s];
        end
      end
    end
  end

  // stage 1: clamp, one minus, trace, 3 lambda + 2 mu, 6 E
  logic signed [EW-1:0]  e_in [NCOMP];
  logic [QW-1:0]         phi_c, k_c;
  logic [QW-1:0]         om_next, ok_next;
  logic signed [TW-1:0]  tr_next;
  logic [LW-1:0]         lm_next;
  logic signed [E6W-1:0] e6_next [NCOMP];

  logic [QW-1:0]         s1_om, s1_ok, s1_k;
  logic signed [TW-1:0]  s1_tr;
  logic [LW-1:0]         s1_lm;
  logic [MODW-1:0]       s1_mu;
  logic signed [E6W-1:0] s1_e6 [NCOMP];

  always_comb begin
    e_in[0] = point.strain_xx;
    e_in[1] = point.strain_xy;
    e_in[2] = point.strain_xz;
    e_in[3] = point.strain_yx;
    e_in[4] = point.strain_yy;
    e_in[5] = point.strain_yz;
    e_in[6] = point.strain_zx;
    e_in[7] = point.strain_zy;
    e_in[8] = point.strain_zz;
    phi_c = (point.damage > pfds_pkg::ONE_Q16) ? pfds_pkg::ONE_Q16 : point.damage;
    k_c   = (k_reg > pfds_pkg::ONE_Q16) ? pfds_pkg::ONE_Q16 : k_reg;
    om_next = pfds_pkg::ONE_Q16 - phi_c;
    ok_next = pfds_pkg::ONE_Q16 - k_c;
    tr_next = '0;
    for (int i = 0; i < DIM; i++) begin
      tr_next = tr_next + TW'(e_in[i*NAX+i]);
    end
    lm_next = (LW'(point.lame_first) << 1) + LW'(point.lame_first)
            + (LW'(point.shear_modulus) << 1);
    for (int l = 0; l < NCOMP; l++) begin
      e6_next[l] = (E6W'(e_in[l]) <<< 2) + (E6W'(e_in[l]) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PREP]) begin
      s1_om <= om_next;
      s1_ok <= ok_next;
      s1_k  <= k_c;
      s1_tr <= tr_next;
      s1_lm <= lm_next;
      s1_mu <= point.shear_modulus;
      s1_e6 <= e6_next;
    end
  end

  // stage 2: (1-phi)^2, lane coefficients, lm * tr
  logic signed [CW-1:0] c_next [NCOMP];
  logic [OM2W-1:0]      s2_om2;
  logic [QW-1:0]        s2_ok, s2_k;
  logic [MODW-1:0]      s2_mu;
  logic signed [CW-1:0] s2_c [NCOMP];
  logic signed [AW-1:0] s2_lmtr;
  logic                 s2_neg;

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      for (int j = 0; j < NAX; j++) begin
        if (i == j) begin
          c_next[i*NAX+j] = CW'(s1_e6[i*NAX+j]) - (CW'(s1_tr) <<< 1);
        end else begin
          c_next[i*NAX+j] = CW'(s1_e6[i*NAX+j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_COEF]) begin
      s2_om2  <= OM2W'(s1_om) * OM2W'(s1_om);
      s2_ok   <= s1_ok;
      s2_k    <= s1_k;
      s2_mu   <= s1_mu;
      s2_c    <= c_next;
      s2_lmtr <= $signed(AW'(s1_lm)) * AW'(s1_tr);
      s2_neg  <= s1_tr[TW-1];
    end
  end

  // stage 3: (1-phi)^2 (1-k), mu * coefficient
  logic signed [AW-1:0] mc_next [NCOMP];
  logic [GW-1:0]        s3_gp;
  logic [QW-1:0]        s3_k;
  logic signed [AW-1:0] s3_mc [NCOMP];
  logic signed [AW-1:0] s3_lmtr;
  logic                 s3_neg;

  always_comb begin
    for (int l = 0; l < NCOMP; l++) begin
      mc_next[l] = $signed(AW'(s2_mu)) * AW'(s2_c[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MULA]) begin
      s3_gp   <= GW'(s2_om2) * GW'(s2_ok);
      s3_k    <= s2_k;
      s3_mc   <= mc_next;
      s3_lmtr <= s2_lmtr;
      s3_neg  <= s2_neg;
    end
  end

  // stage 4: g, and each lane as g * a + (2b + 3) * 2^47
  // with a nonnegative trace the volumetric part folds into a, else into b
  logic signed [AW-1:0] a_next [NCOMP];
  logic signed [BW-1:0] bb_next [NCOMP];
  logic [GW-1:0]        s4_g;
  logic signed [AW-1:0] s4_a [NCOMP];
  logic signed [BW-1:0] s4_bb [NCOMP];

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      for (int j = 0; j < NAX; j++) begin
        if (i == j && !s3_neg) begin
          a_next[i*NAX+j] = s3_mc[i*NAX+j] + s3_lmtr;
        end else begin
          a_next[i*NAX+j] = s3_mc[i*NAX+j];
        end
        if (i == j && s3_neg) begin
          bb_next[i*NAX+j] = (BW'(s3_lmtr) <<< 1) + RND_HALF;
        end else begin
          bb_next[i*NAX+j] = RND_HALF;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_ACOL]) begin
      s4_g  <= s3_gp + (GW'(s3_k) << (2 * FRAC));
      s4_a  <= a_next;
      s4_bb <= bb_next;
    end
  end

  // stage 5: four partial products of g * a per lane
  logic [GLW-1:0]         g_lo;
  logic [GHW-1:0]         g_hi;
  logic [ALW-1:0]         a_lo [NCOMP];
  logic signed [AHW-1:0]  a_hi [NCOMP];
  logic [PLLW-1:0]        pll_next [NCOMP];
  logic [PLHW-1:0]        plh_next [NCOMP];
  logic signed [PHLW-1:0] phl_next [NCOMP];
  logic signed [PHHW-1:0] phh_next [NCOMP];
  logic [PLLW-1:0]        s5_pll [NCOMP];
  logic [PLHW-1:0]        s5_plh [NCOMP];
  logic signed [PHLW-1:0] s5_phl [NCOMP];
  logic signed [PHHW-1:0] s5_phh [NCOMP];
  logic signed [BW-1:0]   s5_bb [NCOMP];

  always_comb begin
    g_lo = s4_g[GLW-1:0];
    g_hi = s4_g[GW-1:GLW];
    for (int l = 0; l < NCOMP; l++) begin
      a_lo[l] = s4_a[l][ALW-1:0];
      a_hi[l] = $signed(s4_a[l][AW-1:ALW]);
      pll_next[l] = PLLW'(g_lo) * PLLW'(a_lo[l]);
      plh_next[l] = PLHW'(g_hi) * PLHW'(a_lo[l]);
      phl_next[l] = $signed(PHLW'(g_lo)) * PHLW'(a_hi[l]);
      phh_next[l] = $signed(PHHW'(g_hi)) * PHHW'(a_hi[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PP]) begin
      s5_pll <= pll_next;
      s5_plh <= plh_next;
      s5_phl <= phl_next;
      s5_phh <= phh_next;
      s5_bb  <= s4_bb;
    end
  end

  // stages 6 to 8: sum the partial products, then add the b and rounding term
  logic signed [XW-1:0] s6_lo [NCOMP];
  logic signed [XW-1:0] s6_hi [NCOMP];
  logic signed [BW-1:0] s6_bb [NCOMP];
  logic signed [XW-1:0] s7_x [NCOMP];
  logic signed [BW-1:0] s7_bb [NCOMP];
  logic signed [XW-1:0] s8_y [NCOMP];

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM1]) begin
      for (int l = 0; l < NCOMP; l++) begin
        s6_lo[l] <= $signed(XW'(s5_pll[l]) + (XW'(s5_plh[l]) << GLW));
        s6_hi[l] <= (XW'(s5_phl[l]) <<< ALW) + (XW'(s5_phh[l]) <<< (GLW + ALW));
      end
      s6_bb <= s5_bb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_SUM2]) begin
      for (int l = 0; l < NCOMP; l++) begin
        s7_x[l] <= s6_lo[l] + s6_hi[l];
      end
      s7_bb <= s6_bb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_RND]) begin
      for (int l = 0; l < NCOMP; l++) begin
        s8_y[l] <= s7_x[l] + (XW'(s7_bb[l]) <<< (QSH - 1));
      end
    end
  end

  // stage 9: floor by 2^48, then a magnitude so that floor(z/3) becomes
  // a plain unsigned divide (negative z maps to 2 - z)
  logic [ZW-1:0] z_u [NCOMP];
  logic [ZW-1:0] dv [DIV_STAGES+1][NCOMP];
  logic [1:0]    dr [DIV_STAGES+1][NCOMP];
  logic          dn [DIV_STAGES+1][NCOMP];

  always_comb begin
    for (int l = 0; l < NCOMP; l++) begin
      z_u[l] = s8_y[l][XW-1:QSH];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_MAG]) begin
      for (int l = 0; l < NCOMP; l++) begin
        dn[0][l] <= z_u[l][ZW-1];
        dv[0][l] <= z_u[l][ZW-1] ? (ZW'(2) - z_u[l]) : z_u[l];
        dr[0][l] <= '0;
      end
    end
  end

  // stages 10 to 12: quotient digits replace the dividend from the top down
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    div3_t         step [NCOMP];
    logic [ZW-1:0] dv_next [NCOMP];

    always_comb begin
      for (int l = 0; l < NCOMP; l++) begin
        step[l] = div3_chunk(dr[s][l], dv[s][l][ZW-1-s*CHW -: CHW]);
        dv_next[l] = dv[s][l];
        dv_next[l][ZW-1-s*CHW -: CHW] = step[l].q;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_DIV0+s]) begin
        for (int l = 0; l < NCOMP; l++) begin
          dv[s+1][l] <= dv_next[l];
          dr[s+1][l] <= step[l].r;
          dn[s+1][l] <= dn[s][l];
        end
      end
    end
  end

  // stage 13: sign, saturation and unused components in two dimensions
  logic [SW-1:0]     res [NCOMP];
  logic [ZW-1:0]     qv;
  pfds_pkg::stress_t stress_next;
  pfds_pkg::stress_t stress_q;

  always_comb begin
    qv = '0;
    for (int i = 0; i < NAX; i++) begin
      for (int j = 0; j < NAX; j++) begin
        qv = dv[DIV_STAGES][i*NAX+j];
        if (i >= DIM || j >= DIM) begin
          res[i*NAX+j] = '0;
        end else if (!dn[DIV_STAGES][i*NAX+j]) begin
          res[i*NAX+j] = (qv[ZW-1:SW-1] != '0) ? SAT_MAX : qv[SW-1:0];
        end else if (qv[ZW-1:SW] != '0 || (qv[SW-1] && qv[SW-2:0] != '0)) begin
          res[i*NAX+j] = SAT_MIN;
        end else begin
          res[i*NAX+j] = SW'(0) - qv[SW-1:0];
        end
      end
    end
    stress_next.stress_xx = res[0];
    stress_next.stress_xy = res[1];
    stress_next.stress_xz = res[2];
    stress_next.stress_yx = res[3];
    stress_next.stress_yy = res[4];
    stress_next.stress_yz = res[5];
    stress_next.stress_zx = res[6];
    stress_next.stress_zy = res[7];
    stress_next.stress_zz = res[8];
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_OUT]) begin
      stress_q <= stress_next;
    end
  end

  assign stress = stress_q;

endmodule
